// ----- src/ddph_pkg.sv -----
// Shared types and constants for the drive-distance PID block with heading hold.
// Used by the register file, the state stage, the math stages and the top level.
// No dependencies.
package ddph_pkg;

    localparam int AddrW = 5;

    // register indexes on the configuration port
    localparam logic [2:0] RegTarget   = 3'd0;
    localparam logic [2:0] RegSpeed    = 3'd1;
    localparam logic [2:0] RegHeadRef  = 3'd2;
    localparam logic [2:0] RegUseStart = 3'd3;
    localparam logic [2:0] RegTimeout  = 3'd4;
    localparam logic [2:0] RegGainP    = 3'd5;
    localparam logic [2:0] RegGainI    = 3'd6;
    localparam logic [2:0] RegGainD    = 3'd7;

    localparam int PosW   = 24;
    localparam int HeadW  = 20;
    localparam int ErrW   = 25;
    localparam int DerrW  = 26;
    localparam int IntW   = 12;
    localparam int IsumW  = 24;
    localparam int DhW    = 21;
    localparam int MagW   = 10;
    localparam int PpW    = 42;
    localparam int PdW    = 43;
    localparam int SumW   = 45;
    localparam int PowW   = 16;
    localparam int CorrW  = 13;

    localparam logic signed [IsumW-1:0] IntLim   = 24'sd1280;
    localparam logic signed [ErrW-1:0]  ErrWin   = 25'sd20;
    localparam logic [DhW-1:0]          HeadBig  = 21'd834;
    localparam logic [21:0]             CorrRecip = 22'd3221226;
    localparam logic [11:0]             CorrLim  = 12'd2560;
    localparam logic [6:0]              SpeedMax = 7'd100;

    typedef struct packed {
        logic signed [23:0] target_position;
        logic [6:0]         speed_limit;
        logic signed [19:0] heading_ref;
        logic               use_start_heading;
        logic [15:0]        timeout_ticks;
        logic [15:0]        gain_p;
        logic [15:0]        gain_i;
        logic [15:0]        gain_d;
    } cfg_t;

    // per-sample result of the state stage
    typedef struct packed {
        logic                   done;
        logic                   tmo;
        logic signed [ErrW-1:0] err;
        logic signed [DerrW-1:0] derr;
        logic signed [IntW-1:0] integ;
        logic                   head_neg;
        logic                   head_big;
        logic [MagW-1:0]        head_mag;
    } s1_t;

endpackage

// ----- src/drive_distance_pid_heading_hold.sv -----
// Top level of the drive-distance PID controller with heading hold.
// Depends on ddph_pkg, ddph_regs, ddph_state and ddph_math.
//
// Takes one sensor sample per request (restart flag, both front encoder positions,
// gyro heading) and returns one drive request with right and left power, done and
// timeout flags. The path is a four-register pipeline: input register, state stage
// (error, integral, tick count, held heading), product stage (gain multiplies and
// heading correction) and result register. A sample may be accepted every cycle
// while the output side is not stalled. Each stage holds its request until the next
// stage has room, so input stops once every stage is full behind a waiting result.
// The user must write registers over the APB-style port only while no sample is in
// flight; the block itself does not enforce this.
module drive_distance_pid_heading_hold (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ddph_pkg::AddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       restart,
    input  logic signed [23:0]         right_position,
    input  logic signed [23:0]         left_position,
    input  logic signed [19:0]         heading,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [7:0]          right_power,
    output logic signed [7:0]          left_power,
    output logic                       done_res,
    output logic                       timed_out
);

    ddph_pkg::cfg_t cfg;
    ddph_pkg::s1_t  s1_data;
    logic           s1_valid;
    logic           s1_ready;

    ddph_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ddph_state u_state (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .restart        (restart),
        .right_position (right_position),
        .left_position  (left_position),
        .heading        (heading),
        .s1_valid       (s1_valid),
        .s1_ready       (s1_ready),
        .s1_data        (s1_data)
    );

    ddph_math u_math (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .s1_valid    (s1_valid),
        .s1_ready    (s1_ready),
        .s1_data     (s1_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .right_power (right_power),
        .left_power  (left_power),
        .done_res    (done_res),
        .timed_out   (timed_out)
    );

endmodule

// ----- src/ddph_regs.sv -----
// Configuration register file on an APB-style port.
// Depends on ddph_pkg for the register indexes and the cfg_t bundle.
module ddph_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ddph_pkg::AddrW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output ddph_pkg::cfg_t            cfg
);

    ddph_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_position   <= '0;
            cfg_reg.speed_limit       <= 7'd100;
            cfg_reg.heading_ref       <= '0;
            cfg_reg.use_start_heading <= 1'b1;
            cfg_reg.timeout_ticks     <= 16'd65535;
            cfg_reg.gain_p            <= 16'd107;
            cfg_reg.gain_i            <= 16'd4;
            cfg_reg.gain_d            <= 16'd845;
        end
        else if (wr_en)
        begin
            unique case (idx)
                ddph_pkg::RegTarget:   cfg_reg.target_position   <= pwdata[23:0];
                ddph_pkg::RegSpeed:    cfg_reg.speed_limit       <= pwdata[6:0];
                ddph_pkg::RegHeadRef:  cfg_reg.heading_ref       <= pwdata[19:0];
                ddph_pkg::RegUseStart: cfg_reg.use_start_heading <= pwdata[0];
                ddph_pkg::RegTimeout:  cfg_reg.timeout_ticks     <= pwdata[15:0];
                ddph_pkg::RegGainP:    cfg_reg.gain_p            <= pwdata[15:0];
                ddph_pkg::RegGainI:    cfg_reg.gain_i            <= pwdata[15:0];
                ddph_pkg::RegGainD:    cfg_reg.gain_d            <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            ddph_pkg::RegTarget:
                prdata = {{8{cfg_reg.target_position[23]}}, cfg_reg.target_position};
            ddph_pkg::RegSpeed:    prdata = {25'd0, cfg_reg.speed_limit};
            ddph_pkg::RegHeadRef:
                prdata = {{12{cfg_reg.heading_ref[19]}}, cfg_reg.heading_ref};
            ddph_pkg::RegUseStart: prdata = {31'd0, cfg_reg.use_start_heading};
            ddph_pkg::RegTimeout:  prdata = {16'd0, cfg_reg.timeout_ticks};
            ddph_pkg::RegGainP:    prdata = {16'd0, cfg_reg.gain_p};
            ddph_pkg::RegGainI:    prdata = {16'd0, cfg_reg.gain_i};
            ddph_pkg::RegGainD:    prdata = {16'd0, cfg_reg.gain_d};
            default:               prdata = '0;
        endcase
    end

endmodule

// ----- src/ddph_state.sv -----
// Input register and per-move state: error, integral, tick count, held heading.
// Depends on ddph_pkg for cfg_t, s1_t and the fixed-point widths.
module ddph_state (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ddph_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          restart,
    input  logic signed [23:0]            right_position,
    input  logic signed [23:0]            left_position,
    input  logic signed [19:0]            heading,
    output logic                          s1_valid,
    input  logic                          s1_ready,
    output ddph_pkg::s1_t                 s1_data
);

    // input register
    logic               v0_reg;
    logic               rst0_reg;
    logic signed [23:0] rpos_reg;
    logic signed [23:0] lpos_reg;
    logic signed [19:0] head_reg;

    // move state
    logic signed [ddph_pkg::IntW-1:0] integ_reg, integ_next;
    logic signed [ddph_pkg::ErrW-1:0] prev_reg, prev_next;
    logic [15:0]                      tick_reg, tick_next;
    logic signed [19:0]               sh_reg, sh_next;
    logic                             fin_reg, fin_next;
    logic                             tflag_reg, tflag_next;

    logic          v1_reg;
    ddph_pkg::s1_t s1_reg, s1_next;

    logic s1_load, step, in_acc;

    logic signed [ddph_pkg::IntW-1:0]  integ_e;
    logic signed [ddph_pkg::ErrW-1:0]  prev_e;
    logic [15:0]                       tick_e;
    logic                              fin_e, tflag_e;
    logic signed [24:0]                pos_sum, mean;
    logic signed [ddph_pkg::ErrW-1:0]  err;
    logic                              tmo_hit, run, err_near;
    logic signed [22:0]                iprod;
    logic signed [ddph_pkg::IsumW-1:0] isum, iclamp;
    logic signed [19:0]                held;
    logic signed [ddph_pkg::DhW-1:0]   dh, dh_mag;

    assign s1_load  = !v1_reg || s1_ready;
    assign in_ready = !v0_reg || s1_load;
    assign in_acc   = in_valid && in_ready;
    assign step     = v0_reg && s1_load;
    assign s1_valid = v1_reg;
    assign s1_data  = s1_reg;

    always_comb
    begin
        // restart clears the move before this sample is handled
        integ_e = rst0_reg ? '0 : integ_reg;
        prev_e  = rst0_reg ? '0 : prev_reg;
        tick_e  = rst0_reg ? '0 : tick_reg;
        fin_e   = rst0_reg ? 1'b0 : fin_reg;
        tflag_e = rst0_reg ? 1'b0 : tflag_reg;
        sh_next = rst0_reg ? head_reg : sh_reg;

        pos_sum = {lpos_reg[23], lpos_reg} + {rpos_reg[23], rpos_reg};
        mean    = pos_sum >>> 1;
        err     = {cfg.target_position[23], cfg.target_position} - mean;

        tmo_hit    = !fin_e && (tick_e >= cfg.timeout_ticks);
        run        = !fin_e && !tmo_hit && (err != '0);
        fin_next   = !run;
        tflag_next = tflag_e || tmo_hit;
        tick_next  = (!fin_e && !tmo_hit) ? tick_e + 16'd1 : tick_e;

        err_near = (err > -ddph_pkg::ErrWin) && (err < ddph_pkg::ErrWin);
        iprod    = $signed({1'b0, cfg.gain_i}) * $signed(err[5:0]);
        isum     = {{(ddph_pkg::IsumW - ddph_pkg::IntW){integ_e[ddph_pkg::IntW-1]}}, integ_e}
                 + (err_near ? {iprod[22], iprod} : '0);
        if (isum > ddph_pkg::IntLim)
            iclamp = ddph_pkg::IntLim;
        else if (isum < -ddph_pkg::IntLim)
            iclamp = -ddph_pkg::IntLim;
        else
            iclamp = isum;

        integ_next = run ? iclamp[ddph_pkg::IntW-1:0] : integ_e;
        prev_next  = run ? err : prev_e;

        held   = cfg.use_start_heading ? sh_next : cfg.heading_ref;
        dh     = {head_reg[19], head_reg} - {held[19], held};
        dh_mag = dh[ddph_pkg::DhW-1] ? -dh : dh;

        s1_next.done     = !run;
        s1_next.tmo      = tflag_next;
        s1_next.err      = err;
        s1_next.derr     = {err[ddph_pkg::ErrW-1], err} - {prev_e[ddph_pkg::ErrW-1], prev_e};
        s1_next.integ    = integ_next;
        s1_next.head_neg = dh[ddph_pkg::DhW-1];
        s1_next.head_big = dh_mag >= ddph_pkg::HeadBig;
        s1_next.head_mag = dh_mag[ddph_pkg::MagW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            integ_reg <= '0;
            prev_reg  <= '0;
            tick_reg  <= '0;
            sh_reg    <= '0;
            fin_reg   <= 1'b0;
            tflag_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
                v0_reg <= 1'b1;
            else if (step)
                v0_reg <= 1'b0;

            if (s1_load)
                v1_reg <= v0_reg;

            if (step)
            begin
                integ_reg <= integ_next;
                prev_reg  <= prev_next;
                tick_reg  <= tick_next;
                sh_reg    <= sh_next;
                fin_reg   <= fin_next;
                tflag_reg <= tflag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rst0_reg <= restart;
            rpos_reg <= right_position;
            lpos_reg <= left_position;
            head_reg <= heading;
        end
        if (step)
            s1_reg <= s1_next;
    end

endmodule

// ----- src/ddph_math.sv -----
// Gain products, heading correction, power sum, clamps and result register.
// Depends on ddph_pkg for cfg_t, s1_t and the fixed-point widths.
module ddph_math (
    input  logic               clk,
    input  logic               rst_n,
    input  ddph_pkg::cfg_t     cfg,
    input  logic               s1_valid,
    output logic               s1_ready,
    input  ddph_pkg::s1_t      s1_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [7:0]  right_power,
    output logic signed [7:0]  left_power,
    output logic               done_res,
    output logic               timed_out
);

    // product stage
    logic                              v2_reg;
    logic signed [ddph_pkg::PpW-1:0]   pp_reg;
    logic signed [ddph_pkg::PdW-1:0]   pd_reg;
    logic signed [ddph_pkg::IntW-1:0]  integ_reg;
    logic signed [ddph_pkg::CorrW-1:0] corr_reg;
    logic                              done2_reg, tmo2_reg;

    // result register
    logic              ov_reg;
    logic signed [7:0] rp_reg, lp_reg;
    logic              done_reg, tmo_reg;

    logic out_load, s2_load;

    logic [31:0]                       qprod;
    logic [11:0]                       cmag;
    logic signed [ddph_pkg::CorrW-1:0] corr;
    logic signed [ddph_pkg::SumW-1:0]  psum, lim;
    logic [6:0]                        spd;
    logic signed [ddph_pkg::PowW-1:0]  power, lsum, rq, lq;

    assign out_load = !ov_reg || out_ready;
    assign s2_load  = !v2_reg || out_load;
    assign s1_ready = s2_load;

    assign out_valid   = ov_reg;
    assign right_power = rp_reg;
    assign left_power  = lp_reg;
    assign done_res    = done_reg;
    assign timed_out   = tmo_reg;

    always_comb
    begin
        // 3221226 / 2^20 is 384/125 rounded up, exact over the unclamped range
        qprod = {22'd0, s1_data.head_mag} * {10'd0, ddph_pkg::CorrRecip};
        cmag  = s1_data.head_big ? ddph_pkg::CorrLim : qprod[31:20];
        corr  = s1_data.head_neg ? $signed({1'b0, cmag}) : -$signed({1'b0, cmag});
    end

    always_comb
    begin
        psum = {{(ddph_pkg::SumW - ddph_pkg::PpW){pp_reg[ddph_pkg::PpW-1]}}, pp_reg}
             + {{(ddph_pkg::SumW - ddph_pkg::PdW){pd_reg[ddph_pkg::PdW-1]}}, pd_reg}
             + {{(ddph_pkg::SumW - ddph_pkg::IntW){integ_reg[ddph_pkg::IntW-1]}}, integ_reg};
        spd  = (cfg.speed_limit > ddph_pkg::SpeedMax) ? ddph_pkg::SpeedMax : cfg.speed_limit;
        lim  = $signed({{(ddph_pkg::SumW - 15){1'b0}}, spd, 8'd0});
        if (psum > lim)
            power = lim[ddph_pkg::PowW-1:0];
        else if (psum < -lim)
            power = -lim[ddph_pkg::PowW-1:0];
        else
            power = psum[ddph_pkg::PowW-1:0];
        lsum = power + {{(ddph_pkg::PowW - ddph_pkg::CorrW){corr_reg[ddph_pkg::CorrW-1]}},
                        corr_reg};
        // divide by 256 rounding toward zero
        rq = (power[ddph_pkg::PowW-1] ? power + 16'sd255 : power) >>> 8;
        lq = (lsum[ddph_pkg::PowW-1] ? lsum + 16'sd255 : lsum) >>> 8;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (s2_load)
                v2_reg <= s1_valid;
            if (out_load)
                ov_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid)
        begin
            pp_reg    <= $signed({1'b0, cfg.gain_p}) * s1_data.err;
            pd_reg    <= $signed({1'b0, cfg.gain_d}) * s1_data.derr;
            integ_reg <= s1_data.integ;
            corr_reg  <= corr;
            done2_reg <= s1_data.done;
            tmo2_reg  <= s1_data.tmo;
        end
        if (out_load && v2_reg)
        begin
            rp_reg   <= done2_reg ? '0 : rq[7:0];
            lp_reg   <= done2_reg ? '0 : lq[7:0];
            done_reg <= done2_reg;
            tmo_reg  <= done2_reg && tmo2_reg;
        end
    end

endmodule

// ----- tb/ddph_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the drive-distance PID block with heading hold: watches the register
// port and both request channels, predicts each drive request and compares it.
// Depends on ddph_pkg for the register indexes and the address width.
module ddph_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [ddph_pkg::AddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       restart,
    input  logic signed [23:0]         right_position,
    input  logic signed [23:0]         left_position,
    input  logic signed [19:0]         heading,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [7:0]          right_power,
    input  logic signed [7:0]          left_power,
    input  logic                       done_res,
    input  logic                       timed_out,
    output int                         fail_count,
    output int                         pending,
    output int                         finish_count,
    output int                         timeout_count
);

    typedef struct packed {
        logic [7:0] rpow;
        logic [7:0] lpow;
        logic       done;
        logic       tmo;
    } drive_t;

    // register copy
    logic signed [23:0] goal_pos;
    logic [6:0]         spd_lim;
    logic signed [19:0] ref_head;
    logic               hold_start;
    logic [15:0]        tick_budget;
    logic [15:0]        kp;
    logic [15:0]        ki;
    logic [15:0]        kd;

    // controller state
    longint             integ_acc;
    longint             last_err;
    logic [15:0]        tick_cnt;
    logic signed [19:0] start_head;
    logic               move_over;
    logic               ended_by_timeout;

    drive_t             drive_queue[$];
    int                 result_idx;

    function automatic longint clamp_mag(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic drive_t predict_drive(input logic rs, input logic signed [23:0] rpos,
                                             input logic signed [23:0] lpos,
                                             input logic signed [19:0] head);
        drive_t res;
        longint mean;
        longint err;
        longint power;
        longint lim;
        longint held;
        longint corr;
        res = '0;
        err = 0;
        if (rs) begin
            integ_acc        = 0;
            last_err         = 0;
            tick_cnt         = '0;
            move_over        = 1'b0;
            ended_by_timeout = 1'b0;
            start_head       = head;
        end
        if (!move_over) begin
            // budget check wins over the target check
            if (tick_cnt >= tick_budget) begin
                move_over        = 1'b1;
                ended_by_timeout = 1'b1;
            end else begin
                tick_cnt = tick_cnt + 16'd1;
                mean     = (longint'(lpos) + longint'(rpos)) >>> 1;
                err      = longint'(goal_pos) - mean;
                if (err == 0)
                    move_over = 1'b1;
            end
        end
        if (move_over) begin
            res.done = 1'b1;
            res.tmo  = ended_by_timeout;
            return res;
        end
        // integrate only near the target
        if (err > -20 && err < 20)
            integ_acc = integ_acc + longint'(ki) * err;
        integ_acc = clamp_mag(integ_acc, 1280);
        power = longint'(kp) * err + integ_acc + longint'(kd) * (err - last_err);
        lim   = (spd_lim > 7'd100) ? 25600 : longint'(spd_lim) * 256;
        power = clamp_mag(power, lim);
        last_err = err;
        held = hold_start ? longint'(start_head) : longint'(ref_head);
        corr = -(((longint'(head) - held) * 384) / 125);
        corr = clamp_mag(corr, 2560);
        res.rpow = 8'(power / 256);
        res.lpow = 8'((power + corr) / 256);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: result %0d: %s", $time, result_idx, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, $signed(got),
                                      $signed(want)));
    endtask

    always @(posedge clk or negedge rst_n) begin
        drive_t want;
        if (!rst_n) begin
            goal_pos         = '0;
            spd_lim          = 7'd100;
            ref_head         = '0;
            hold_start       = 1'b1;
            tick_budget      = 16'hFFFF;
            kp               = 16'd107;
            ki               = 16'd4;
            kd               = 16'd845;
            integ_acc        = 0;
            last_err         = 0;
            tick_cnt         = '0;
            start_head       = '0;
            move_over        = 1'b0;
            ended_by_timeout = 1'b0;
            drive_queue.delete();
            result_idx       = 0;
            fail_count       = 0;
            pending          = 0;
            finish_count     = 0;
            timeout_count    = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ddph_pkg::AddrW-1:2])
                    ddph_pkg::RegTarget:   goal_pos    = pwdata[23:0];
                    ddph_pkg::RegSpeed:    spd_lim     = pwdata[6:0];
                    ddph_pkg::RegHeadRef:  ref_head    = pwdata[19:0];
                    ddph_pkg::RegUseStart: hold_start  = pwdata[0];
                    ddph_pkg::RegTimeout:  tick_budget = pwdata[15:0];
                    ddph_pkg::RegGainP:    kp          = pwdata[15:0];
                    ddph_pkg::RegGainI:    ki          = pwdata[15:0];
                    ddph_pkg::RegGainD:    kd          = pwdata[15:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (drive_queue.size() == 0) begin
                    report_mismatch($sformatf("drive request with none pending: right %0d left %0d",
                                              right_power, left_power));
                end else begin
                    want = drive_queue.pop_front();
                    check_field("right_power", right_power, want.rpow);
                    check_field("left_power", left_power, want.lpow);
                    check_field("done_res", {7'd0, done_res}, {7'd0, want.done});
                    check_field("timed_out", {7'd0, timed_out}, {7'd0, want.tmo});
                    if (want.done)
                        finish_count++;
                    if (want.tmo)
                        timeout_count++;
                end
                result_idx++;
            end
            if (in_valid && in_ready)
                drive_queue.push_back(predict_drive(restart, right_position, left_position,
                                                    heading));
            pending = drive_queue.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Top of the testbench for drive_distance_pid_heading_hold: clock, reset, register
// writes, sample stimulus and output back-pressure. Depends on ddph_pkg, the block
// and ddph_checker, which predicts and compares every drive request.
module tb;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ddph_pkg::AddrW-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_ready;
    logic                       restart;
    logic signed [23:0]         right_position;
    logic signed [23:0]         left_position;
    logic signed [19:0]         heading;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [7:0]          right_power;
    logic signed [7:0]          left_power;
    logic                       done_res;
    logic                       timed_out;

    int fail_count;
    int pending;
    int finish_count;
    int timeout_count;

    bit rush;      // no idling on either side
    bit hold_out;  // ask the output side for one long hold-off
    int sample_total;
    int move_total;

    drive_distance_pid_heading_hold u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .restart        (restart),
        .right_position (right_position),
        .left_position  (left_position),
        .heading        (heading),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .right_power    (right_power),
        .left_power     (left_power),
        .done_res       (done_res),
        .timed_out      (timed_out)
    );

    ddph_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .restart        (restart),
        .right_position (right_position),
        .left_position  (left_position),
        .heading        (heading),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .right_power    (right_power),
        .left_power     (left_power),
        .done_res       (done_res),
        .timed_out      (timed_out),
        .fail_count     (fail_count),
        .pending        (pending),
        .finish_count   (finish_count),
        .timeout_count  (timeout_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint fit(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint rand_pos();
        logic signed [23:0] v;
        v = 24'($urandom);
        return v;
    endfunction

    function automatic longint rand_head();
        return longint'($urandom_range(0, 720000)) - 360000;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input longint value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_sample(input logic rs, input longint rpos, input longint lpos,
                               input longint head);
        int gap;
        gap = rush ? 0 : $urandom_range(0, 10);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        restart        <= rs;
        right_position <= 24'(fit(rpos, -8388608, 8388607));
        left_position  <= 24'(fit(lpos, -8388608, 8388607));
        heading        <= 20'(fit(head, -360000, 360000));
        do
            @(posedge clk);
        while (!in_ready);
        sample_total++;
    endtask

    // drop valid and hold until every drive request has come back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
    endtask

    initial begin : watchdog
        #2000000;
        $display("timeout: %0d drive requests still outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : drain
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_out) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (200) @(negedge clk);
                hold_out = 1'b0;
            end
            stall = rush ? 0 : $urandom_range(0, 10);
            repeat (stall) begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial begin : stimulus
        longint goal;
        longint offset;
        longint mean;
        longint skew;
        longint base_head;
        int     kind;
        int     move_len;
        logic   rs;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        restart        = 1'b0;
        right_position = '0;
        left_position  = '0;
        heading        = '0;
        rush           = 1'b0;
        hold_out       = 1'b0;
        sample_total   = 0;
        move_total     = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings, no restart yet: held heading stays zero
        send_sample(1'b0, 12, 10, 5000);
        send_sample(1'b0, 8388607, 8388607, 360000);
        send_sample(1'b0, -8388608, -8388608, -360000);
        send_sample(1'b0, -8388608, 8388607, 1);     // odd negative sum rounds down
        send_sample(1'b0, 0, 0, 0);                  // on target
        send_sample(1'b0, 77, 3, -77);               // stays done
        settle();

        // full gains and a three-tick budget
        write_reg(ddph_pkg::RegTarget, 1000);
        write_reg(ddph_pkg::RegTimeout, 3);
        write_reg(ddph_pkg::RegGainP, 65535);
        write_reg(ddph_pkg::RegGainI, 65535);
        write_reg(ddph_pkg::RegGainD, 65535);
        send_sample(1'b1, 990, 990, 12345);
        send_sample(1'b0, 995, 996, 12245);
        send_sample(1'b0, 1011, 1010, 20000);
        send_sample(1'b0, 900, 900, 0);              // budget spent
        send_sample(1'b0, 1000, 1000, 0);
        send_sample(1'b1, 1000, 1001, 0);            // restart lands on target
        settle();

        write_reg(ddph_pkg::RegTimeout, 0);
        send_sample(1'b1, 5, 5, 0);
        settle();

        // no drive, heading correction pinned to its limits
        write_reg(ddph_pkg::RegTimeout, 65535);
        write_reg(ddph_pkg::RegTarget, -8388608);
        write_reg(ddph_pkg::RegSpeed, 0);
        write_reg(ddph_pkg::RegUseStart, 0);
        write_reg(ddph_pkg::RegHeadRef, -360000);
        send_sample(1'b1, 8388607, 8388607, 360000);
        send_sample(1'b0, -100, -100, -360000);
        settle();
        write_reg(ddph_pkg::RegSpeed, 127);
        write_reg(ddph_pkg::RegTarget, 8388607);
        write_reg(ddph_pkg::RegGainP, 0);
        write_reg(ddph_pkg::RegGainI, 0);
        write_reg(ddph_pkg::RegGainD, 0);
        write_reg(ddph_pkg::RegHeadRef, 360000);
        send_sample(1'b1, -8388608, -8388608, -360000);
        settle();
        write_reg(ddph_pkg::RegGainP, 65535);
        write_reg(ddph_pkg::RegGainI, 1);
        write_reg(ddph_pkg::RegTarget, 0);
        write_reg(ddph_pkg::RegHeadRef, 0);
        write_reg(ddph_pkg::RegUseStart, 1);
        send_sample(1'b1, 1, 2, 100);
        send_sample(1'b0, 30, 30, -2000);
        send_sample(1'b0, -19, -19, 101);
        send_sample(1'b0, 19, 20, 99);
        settle();

        // random moves: restart, converge with noise, sometimes hit or time out
        while (sample_total < 520) begin
            move_total++;
            settle();
            rush = ($urandom_range(0, 4) == 0);
            goal = ($urandom_range(0, 9) == 0) ? rand_pos()
                                               : longint'($urandom_range(0, 40000)) - 20000;
            write_reg(ddph_pkg::RegTarget, goal);
            write_reg(ddph_pkg::RegSpeed, ($urandom_range(0, 9) == 0)
                                          ? $urandom_range(101, 127)
                                          : $urandom_range(0, 100));
            write_reg(ddph_pkg::RegHeadRef, rand_head());
            write_reg(ddph_pkg::RegUseStart, $urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       write_reg(ddph_pkg::RegTimeout, 65535);
                1:       write_reg(ddph_pkg::RegTimeout, $urandom_range(0, 8));
                default: write_reg(ddph_pkg::RegTimeout, $urandom_range(10, 60));
            endcase
            write_reg(ddph_pkg::RegGainP, ($urandom_range(0, 3) == 0)
                                          ? $urandom_range(0, 65535)
                                          : $urandom_range(0, 1500));
            write_reg(ddph_pkg::RegGainI, ($urandom_range(0, 3) == 0)
                                          ? $urandom_range(0, 65535)
                                          : $urandom_range(0, 1500));
            write_reg(ddph_pkg::RegGainD, ($urandom_range(0, 3) == 0)
                                          ? $urandom_range(0, 65535)
                                          : $urandom_range(0, 1500));
            move_len = $urandom_range(4, 40);
            if (move_total == 4) begin
                // back up the pipeline behind a stalled output side
                rush     = 1'b1;
                hold_out = 1'b1;
                move_len = 40;
            end
            offset = ($urandom_range(0, 5) == 0) ? rand_pos()
                                                 : longint'($urandom_range(0, 4000)) - 2000;
            base_head = rand_head();
            for (int k = 0; k < move_len; k++) begin
                kind = $urandom_range(0, 19);
                if (kind == 0) begin
                    send_sample(1'($urandom_range(0, 1)), rand_pos(), rand_pos(), rand_head());
                end else begin
                    rs = (k == 0) || (kind == 1);
                    if (kind == 2 || kind == 3)
                        offset = 0;
                    mean = goal - offset;
                    skew = $urandom_range(0, 1) ? longint'($urandom_range(0, 20))
                                                : longint'($urandom_range(0, 100000));
                    send_sample(rs, mean - skew, mean + skew + longint'($urandom_range(0, 1)),
                                base_head + longint'($urandom_range(0, 6000)) - 3000);
                    offset = offset * longint'($urandom_range(30, 95)) / 100
                           + longint'($urandom_range(0, 6)) - 3;
                end
            end
        end
        rush = 1'b0;
        settle();
        repeat (8) @(posedge clk);

        $display("Sent %0d samples over %0d random moves plus directed cases; %0d results done,",
                 sample_total, move_total, finish_count);
        $display("%0d of those by tick budget; gains, speed, budget and heading swept to limits.",
                 timeout_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ddph_pkg.sv
src/ddph_regs.sv
src/ddph_state.sv
src/ddph_math.sv
src/drive_distance_pid_heading_hold.sv
tb/ddph_checker.sv
tb/tb.sv
